// ----- sv/mle_pkg.sv -----
// Shared types, constants and the letter table for the Morse letter encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package mle_pkg;

    // Field and register widths.
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned DUR_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Character bounds of the encoded range.
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7a;

    // Reset values of the duration registers, in milliseconds.
    localparam logic [DUR_W-1:0] DOT_ON_RESET  = 16'd250;
    localparam logic [DUR_W-1:0] DASH_ON_RESET = 16'd1000;
    localparam logic [DUR_W-1:0] GAP_RESET     = 16'd250;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_ON  = 2'd0,
        REG_DASH_ON = 2'd1,
        REG_GAP     = 2'd2
    } cfg_reg_t;

    // One decoded character. The pattern is left-aligned: bit 3 is the first
    // element, and a set bit is a dash. last_elem is the element count less one.
    typedef struct packed {
        logic       bad;
        logic [1:0] last_elem;
        logic [3:0] pattern;
    } letter_t;

    // Morse table, indexed by the letter's offset from 'a'.
    function automatic letter_t letter_lookup(input logic [4:0] idx);
        letter_t l;
        l.bad = 1'b0;
        unique case (idx)
            5'd0:  begin l.last_elem = 2'd1; l.pattern = 4'b0100; end // a
            5'd1:  begin l.last_elem = 2'd3; l.pattern = 4'b1000; end // b
            5'd2:  begin l.last_elem = 2'd3; l.pattern = 4'b1010; end // c
            5'd3:  begin l.last_elem = 2'd2; l.pattern = 4'b1000; end // d
            5'd4:  begin l.last_elem = 2'd0; l.pattern = 4'b0000; end // e
            5'd5:  begin l.last_elem = 2'd3; l.pattern = 4'b0010; end // f
            5'd6:  begin l.last_elem = 2'd2; l.pattern = 4'b1100; end // g
            5'd7:  begin l.last_elem = 2'd3; l.pattern = 4'b0000; end // h
            5'd8:  begin l.last_elem = 2'd1; l.pattern = 4'b0000; end // i
            5'd9:  begin l.last_elem = 2'd3; l.pattern = 4'b0111; end // j
            5'd10: begin l.last_elem = 2'd2; l.pattern = 4'b1010; end // k
            5'd11: begin l.last_elem = 2'd3; l.pattern = 4'b0100; end // l
            5'd12: begin l.last_elem = 2'd1; l.pattern = 4'b1100; end // m
            5'd13: begin l.last_elem = 2'd1; l.pattern = 4'b1000; end // n
            5'd14: begin l.last_elem = 2'd2; l.pattern = 4'b1110; end // o
            5'd15: begin l.last_elem = 2'd3; l.pattern = 4'b0110; end // p
            5'd16: begin l.last_elem = 2'd3; l.pattern = 4'b1101; end // q
            5'd17: begin l.last_elem = 2'd2; l.pattern = 4'b0100; end // r
            5'd18: begin l.last_elem = 2'd2; l.pattern = 4'b0000; end // s
            5'd19: begin l.last_elem = 2'd0; l.pattern = 4'b1000; end // t
            5'd20: begin l.last_elem = 2'd2; l.pattern = 4'b0010; end // u
            5'd21: begin l.last_elem = 2'd3; l.pattern = 4'b0001; end // v
            5'd22: begin l.last_elem = 2'd2; l.pattern = 4'b0110; end // w
            5'd23: begin l.last_elem = 2'd3; l.pattern = 4'b1001; end // x
            5'd24: begin l.last_elem = 2'd3; l.pattern = 4'b1011; end // y
            5'd25: begin l.last_elem = 2'd3; l.pattern = 4'b1100; end // z
            default: begin
                // Offsets past 'z' never reach here; treat them as bad.
                l.bad       = 1'b1;
                l.last_elem = 2'd0;
                l.pattern   = 4'b0000;
            end
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mle_decode.sv -----
// Character decoder: maps a character byte to its Morse pattern or a bad mark.
// Depends on mle_pkg.
`default_nettype none

module mle_decode (
    input  wire logic [mle_pkg::CHAR_W-1:0] char_code,
    output mle_pkg::letter_t                letter
);
    import mle_pkg::*;

    logic [4:0] offset;
    logic       in_range;

    // Range check and table lookup on the offset from 'a'.
    always_comb begin
        offset   = char_code[4:0] - CHAR_A[4:0];
        in_range = (char_code >= CHAR_A) && (char_code <= CHAR_Z);
        if (in_range) begin
            letter = letter_lookup(offset);
        end else begin
            letter.bad       = 1'b1;
            letter.last_elem = 2'd0;
            letter.pattern   = 4'b0000;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mle_seq.sv -----
// Segment sequencer: holds one decoded character, steps through its segments
// and drives the registered result channel. Depends on mle_pkg.
`default_nettype none

module mle_seq (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire mle_pkg::letter_t          in_letter,
    input  wire logic [mle_pkg::DUR_W-1:0] dot_on,
    input  wire logic [mle_pkg::DUR_W-1:0] dash_on,
    input  wire logic [mle_pkg::DUR_W-1:0] gap,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_level,
    output logic [mle_pkg::DUR_W-1:0]      out_duration,
    output logic                           out_bad,
    output logic                           out_last
);
    import mle_pkg::*;

    logic             hold_valid_reg, hold_valid_next;
    letter_t          hold_reg, hold_next;
    logic [2:0]       seg_reg, seg_next;
    logic             m_valid_reg, m_valid_next;
    logic             level_reg, level_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic             bad_reg, bad_next;
    logic             last_reg, last_next;

    logic             out_load;
    logic             seg_last;
    logic             is_dash;
    logic             accept;

    // The output register takes a segment when it is empty or being drained.
    always_comb begin
        out_load = hold_valid_reg && (!m_valid_reg || out_ready);
        seg_last = hold_reg.bad || (seg_reg[0] && (seg_reg[2:1] == hold_reg.last_elem));
        is_dash  = hold_reg.pattern[~seg_reg[2:1]];
        in_ready = !hold_valid_reg || (out_load && seg_last);
        accept   = in_valid && in_ready;
    end

    // Holding register and segment counter.
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        seg_next        = seg_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
            hold_next       = in_letter;
            seg_next        = 3'd0;
        end else if (out_load && seg_last) begin
            hold_valid_next = 1'b0;
        end else if (out_load) begin
            seg_next = seg_reg + 3'd1;
        end
    end

    // Segment formation: even steps are the high part, odd steps the gap.
    always_comb begin
        m_valid_next = m_valid_reg;
        level_next   = level_reg;
        dur_next     = dur_reg;
        bad_next     = bad_reg;
        last_next    = last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            last_next    = seg_last;
            bad_next     = hold_reg.bad;
            if (hold_reg.bad) begin
                level_next = 1'b0;
                dur_next   = '0;
            end else begin
                level_next = !seg_reg[0];
                dur_next   = seg_reg[0] ? gap : (is_dash ? dash_on : dot_on);
            end
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        hold_reg  <= hold_next;
        seg_reg   <= seg_next;
        level_reg <= level_next;
        dur_reg   <= dur_next;
        bad_reg   <= bad_next;
        last_reg  <= last_next;
    end

    assign out_valid    = m_valid_reg;
    assign out_level    = level_reg;
    assign out_duration = dur_reg;
    assign out_bad      = bad_reg;
    assign out_last     = last_reg;

endmodule

`default_nettype wire

// ----- sv/morse_letter_encoder.sv -----
// Morse letter encoder top level: duration registers, decoder and sequencer.
// Depends on mle_pkg, mle_decode and mle_seq.
//
// Usage:
// The input channel (s_valid/s_ready/s_char_code) takes one character byte per
// request. A letter 'a' to 'z' produces two to eight segments on the result
// channel (m_valid/m_ready and payload): a high segment of the dot or dash
// time followed by a low segment of the gap time for each element, with
// m_last on the final low segment. Any other byte produces one segment with
// m_bad_char, m_last, level low and zero duration.
// The accepted character waits in the sequencer's holding register, from which
// its segments pass into the output register. Segments leave at one per cycle
// while the receiver takes them; the next character is taken in the cycle its
// predecessor's last segment enters the output register.
// When the receiver stalls, the output register holds its segment and the
// sequencer waits; s_ready stays low while a held character cannot advance.
// Reset clears all pending work and loads the durations with 250, 1000 and
// 250 ms. The durations are written over cfg_wr_en/cfg_index/cfg_wdata; the
// user must do so only while the block is idle, which the block does not
// enforce. Writes to index 3 are ignored.
`default_nettype none

module morse_letter_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mle_pkg::CHAR_W-1:0]    s_char_code,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_level,
    output logic [mle_pkg::DUR_W-1:0]          m_duration_ms,
    output logic                               m_bad_char,
    output logic                               m_last,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mle_pkg::DUR_W-1:0]     cfg_wdata
);
    import mle_pkg::*;

    logic [DUR_W-1:0] dot_on_reg, dot_on_next;
    logic [DUR_W-1:0] dash_on_reg, dash_on_next;
    logic [DUR_W-1:0] gap_reg, gap_next;
    letter_t          letter;

    // Duration register writes.
    always_comb begin
        dot_on_next  = dot_on_reg;
        dash_on_next = dash_on_reg;
        gap_next     = gap_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DOT_ON:  dot_on_next  = cfg_wdata;
                REG_DASH_ON: dash_on_next = cfg_wdata;
                REG_GAP:     gap_next     = cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_on_reg  <= DOT_ON_RESET;
            dash_on_reg <= DASH_ON_RESET;
            gap_reg     <= GAP_RESET;
        end else begin
            dot_on_reg  <= dot_on_next;
            dash_on_reg <= dash_on_next;
            gap_reg     <= gap_next;
        end
    end

    // Character decode feeds the sequencer's holding register.
    mle_decode u_decode (
        .char_code (s_char_code),
        .letter    (letter)
    );

    mle_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_letter    (letter),
        .dot_on       (dot_on_reg),
        .dash_on      (dash_on_reg),
        .gap          (gap_reg),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_level    (m_level),
        .out_duration (m_duration_ms),
        .out_bad      (m_bad_char),
        .out_last     (m_last)
    );

endmodule

`default_nettype wire

// ----- sv/mle_checker.sv -----
// Port-level checks for the Morse letter encoder, bound to its top level.
// Depends on mle_pkg and morse_letter_encoder.
`default_nettype none

module mle_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [mle_pkg::CHAR_W-1:0]    s_char_code,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_level,
    input wire logic [mle_pkg::DUR_W-1:0]     m_duration_ms,
    input wire logic                          m_bad_char,
    input wire logic                          m_last
);

    // A waiting request keeps its character until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_char_code))
        else $error("request changed while waiting");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_duration_ms)
            && $stable(m_bad_char) && $stable(m_last))
        else $error("result changed while stalled");

    // An error result is a single low, zero-length, final segment.
    a_bad_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_char |-> m_last && !m_level && (m_duration_ms == '0))
        else $error("malformed error result");

    // A high segment is never the final one.
    a_high_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_level |-> !m_last && !m_bad_char)
        else $error("high segment marked last or bad");

    // A taken high segment is followed at once by its low gap.
    a_gap_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_level |=> m_valid && !m_level && !m_bad_char)
        else $error("high segment not followed by gap");

endmodule

bind morse_letter_encoder mle_checker u_mle_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Morse letter encoder: directed and random characters,
// duration register settings, random idling and a long output stall.
// Depends on mle_pkg and morse_letter_encoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mle_pkg::*;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 40;

    // One timed level segment as the block should deliver it.
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
        logic             bad;
        logic             last;
    } segment_t;

    // Element count and dash flags; bit 3 is the first element.
    typedef struct packed {
        logic [2:0] count;
        logic [3:0] dashes;
    } morse_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CHAR_W-1:0]    s_char_code;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_level;
    logic [DUR_W-1:0]     m_duration_ms;
    logic                 m_bad_char;
    logic                 m_last;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_wdata;

    // Current durations as the block should hold them.
    logic [DUR_W-1:0] cur_dot_ms;
    logic [DUR_W-1:0] cur_dash_ms;
    logic [DUR_W-1:0] cur_gap_ms;

    segment_t expected_segments[$];
    int       mismatch_count = 0;
    int       burst_left     = 0;
    bit       use_gaps       = 1'b1;
    bit       stall_enable   = 1'b1;
    int       hold_request   = 0;

    morse_letter_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_duration_ms (m_duration_ms),
        .m_bad_char    (m_bad_char),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Morse table of the lower-case letters.
    function automatic morse_t morse_of(input logic [CHAR_W-1:0] c);
        morse_t m;
        case (c)
            "a": m = {3'd2, 4'b0100};
            "b": m = {3'd4, 4'b1000};
            "c": m = {3'd4, 4'b1010};
            "d": m = {3'd3, 4'b1000};
            "e": m = {3'd1, 4'b0000};
            "f": m = {3'd4, 4'b0010};
            "g": m = {3'd3, 4'b1100};
            "h": m = {3'd4, 4'b0000};
            "i": m = {3'd2, 4'b0000};
            "j": m = {3'd4, 4'b0111};
            "k": m = {3'd3, 4'b1010};
            "l": m = {3'd4, 4'b0100};
            "m": m = {3'd2, 4'b1100};
            "n": m = {3'd2, 4'b1000};
            "o": m = {3'd3, 4'b1110};
            "p": m = {3'd4, 4'b0110};
            "q": m = {3'd4, 4'b1101};
            "r": m = {3'd3, 4'b0100};
            "s": m = {3'd3, 4'b0000};
            "t": m = {3'd1, 4'b1000};
            "u": m = {3'd3, 4'b0010};
            "v": m = {3'd4, 4'b0001};
            "w": m = {3'd3, 4'b0110};
            "x": m = {3'd4, 4'b1001};
            "y": m = {3'd4, 4'b1011};
            default: m = {3'd4, 4'b1100}; // z; callers pass letters only
        endcase
        return m;
    endfunction

    // Work out the segments one accepted character should produce.
    task automatic predict_segments(input logic [CHAR_W-1:0] c);
        morse_t   m;
        segment_t seg;
        int       i;
        if (c < CHAR_A || c > CHAR_Z) begin
            seg.level    = 1'b0;
            seg.duration = '0;
            seg.bad      = 1'b1;
            seg.last     = 1'b1;
            expected_segments.push_back(seg);
        end else begin
            m = morse_of(c);
            for (i = 0; i < m.count; i++) begin
                seg.level    = 1'b1;
                seg.duration = m.dashes[3-i] ? cur_dash_ms : cur_dot_ms;
                seg.bad      = 1'b0;
                seg.last     = 1'b0;
                expected_segments.push_back(seg);
                seg.level    = 1'b0;
                seg.duration = cur_gap_ms;
                seg.last     = (i + 1 == m.count);
                expected_segments.push_back(seg);
            end
        end
    endtask

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Offer one character, with a random gap at the start of each burst.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = use_gaps ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_segments(c);
    endtask

    // Stop offering requests and let every pending segment come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_segments.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write; the enable is lowered on the following edge.
    task automatic write_duration(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DUR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DOT_ON:  cur_dot_ms  = value;
            REG_DASH_ON: cur_dash_ms = value;
            REG_GAP:     cur_gap_ms  = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic program_durations(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                                     input logic [DUR_W-1:0] gap);
        wait_idle();
        write_duration(REG_DOT_ON, dot);
        write_duration(REG_DASH_ON, dash);
        write_duration(REG_GAP, gap);
    endtask

    // A random duration, with the extremes drawn often.
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'hffff;
            2: return 16'd0;
            default: return DUR_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Mostly letters, the rest any byte.
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 99) < 85)
            return CHAR_W'($urandom_range(CHAR_A, CHAR_Z));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Reset durations, range edges, every element length and plain letters.
    task automatic test_directed_chars();
        logic [CHAR_W-1:0] chars[$];
        chars = '{8'h00, 8'hff, 8'h60, 8'h7b, 8'h41, 8'h5a, 8'h80, 8'h20,
                  "a", "z", "e", "t", "h", "o", "q", "j", "y", "m", "s", "v", "b"};
        foreach (chars[i]) send_char(chars[i]);
    endtask

    // Zero and full-scale durations, and a write to the unused index.
    task automatic test_register_extremes();
        logic [CHAR_W-1:0] chars[$];
        chars = '{"a", "t", "q", 8'h7b, "x", "e"};
        program_durations(16'd0, 16'hffff, 16'd1);
        foreach (chars[i]) send_char(chars[i]);
        program_durations(16'hffff, 16'd0, 16'hffff);
        foreach (chars[i]) send_char(chars[i]);
        wait_idle();
        write_duration(REG_UNUSED, DUR_W'($urandom_range(0, 65535)));
        write_duration(REG_GAP, 16'd0);
        foreach (chars[i]) send_char(chars[i]);
    endtask

    // Several random settings with random characters under each.
    task automatic test_random_chars();
        int phase;
        int n;
        for (phase = 0; phase < 5; phase++) begin
            program_durations(pick_duration(), pick_duration(), pick_duration());
            if ($urandom_range(0, 1)) begin
                wait_idle();
                write_duration(REG_UNUSED, DUR_W'($urandom_range(0, 65535)));
            end
            // One phase runs with neither side idling.
            use_gaps     = (phase != 2);
            stall_enable = (phase != 2);
            for (n = 0; n < 52; n++) send_char(pick_char());
        end
        use_gaps     = 1'b1;
        stall_enable = 1'b1;
    endtask

    // The receiver holds off while requests keep coming, so the input stalls.
    task automatic test_output_backpressure();
        int n;
        program_durations(DOT_ON_RESET, DASH_ON_RESET, GAP_RESET);
        use_gaps     = 1'b0;
        hold_request = 150;
        for (n = 0; n < 30; n++) send_char(CHAR_W'($urandom_range(CHAR_A, CHAR_Z)));
        use_gaps = 1'b1;
    endtask

    // Receiver: a changing stall pattern, a long hold when one is requested.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!stall_enable) begin
                m_ready <= 1'b1;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // Compare each accepted segment with the oldest prediction.
    always @(posedge aclk) begin
        segment_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_segments.size() == 0) begin
                report_mismatch("segment with none expected, duration",
                                32'(m_duration_ms), 0);
            end else begin
                want = expected_segments.pop_front();
                if (m_level !== want.level)
                    report_mismatch("level", 32'(m_level), 32'(want.level));
                if (m_duration_ms !== want.duration)
                    report_mismatch("duration_ms", 32'(m_duration_ms), 32'(want.duration));
                if (m_bad_char !== want.bad)
                    report_mismatch("bad_char", 32'(m_bad_char), 32'(want.bad));
                if (m_last !== want.last)
                    report_mismatch("last", 32'(m_last), 32'(want.last));
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Test sequence.
    initial begin
        s_valid     = 1'b0;
        s_char_code = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_DOT_ON;
        cfg_wdata   = '0;
        cur_dot_ms  = DOT_ON_RESET;
        cur_dash_ms = DASH_ON_RESET;
        cur_gap_ms  = GAP_RESET;
        aresetn     = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_chars();
        test_register_extremes();
        test_random_chars();
        test_output_backpressure();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (expected_segments.size() != 0)
            report_mismatch("segments still outstanding", expected_segments.size(), 0);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mle_pkg.sv
sv/mle_decode.sv
sv/mle_seq.sv
sv/morse_letter_encoder.sv
sv/mle_checker.sv
tb/sv/tb_top.sv
